>>> hdl/bulge_point_deform_unit_defines.svh
// Assertion macros for the bulge point deform unit.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef BULGE_POINT_DEFORM_UNIT_DEFINES_SVH
`define BULGE_POINT_DEFORM_UNIT_DEFINES_SVH
`ifndef SYNTH
// plain property, sampled on clock, off during reset
`define BPD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// same-cycle implication
`define BPD_ASSERT_IMPLIES(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);
`else
`define BPD_ASSERT(lbl, prop, msg)
`define BPD_ASSERT_IMPLIES(lbl, pre, post, msg)
`endif
`endif

>>> hdl/bpd_pkg.sv
// Shared constants, types and helpers for the bulge point deform unit.
// No dependencies; compiled first.
package bpd_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_BITS = 16;
   localparam int COORD_W     = 32;
   localparam int WEIGHT_W    = 17;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_BITS);

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AXIS_LOW     = 3'd0,
      CSR_AXIS_HIGH    = 3'd1,
      CSR_BULGE_FACTOR = 3'd2,
      CSR_DISP_MASK    = 3'd3,
      CSR_AXIS_SEL     = 3'd4,
      CSR_RADIAL_MODE  = 3'd5
   } csr_index_type;

   // axis codes; the fourth code acts as z
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;
   localparam logic [2:0] DISP_ALL = 3'd7;

   // divider and square root units: one result bit per stage
   localparam int UNIT_STAGES = 32;
   localparam int DIV_Q_W     = UNIT_STAGES;
   localparam int DIV_DEN_W   = 33;
   localparam int DIV_NUM_W   = DIV_DEN_W + FRAC_BITS;
   localparam int SQRT_OUT_W  = UNIT_STAGES;
   localparam int SQRT_IN_W   = 2 * UNIT_STAGES;

   // three front stages, six middle stages, five back stages
   localparam int PIPE_DEPTH = 14 + 2 * UNIT_STAGES;

   localparam int SAT_W = 72;
   localparam logic signed [SAT_W-1:0] SAT_HI = 72'sd2147483647;
   localparam logic signed [SAT_W-1:0] SAT_LO = -72'sd2147483648;

   // data that rides beside the long units
   typedef struct packed {
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic [WEIGHT_W-1:0]       w;
      logic [SQRT_OUT_W-1:0]     d;
      logic signed [COORD_W-1:0] o;
      logic                      neg;
      logic                      zero;
   } bpd_side_type;

   // clip to the signed 32 bit range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
      if (v > SAT_HI) begin
         return 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         return 32'sh80000000;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

>>> hdl/bpd_if.sv
// Valid/ready channel interfaces for point items and result items.
// Depends on bpd_pkg for field widths.
interface bpd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [bpd_pkg::COORD_W-1:0]   point_x;
   logic signed [bpd_pkg::COORD_W-1:0]   point_y;
   logic signed [bpd_pkg::COORD_W-1:0]   point_z;
   logic        [bpd_pkg::WEIGHT_W-1:0]  selection_weight;
   modport source (output valid, output point_x, output point_y, output point_z,
                   output selection_weight, input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   input selection_weight, output ready);
endinterface

interface bpd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bpd_pkg::COORD_W-1:0] out_x;
   logic signed [bpd_pkg::COORD_W-1:0] out_y;
   logic signed [bpd_pkg::COORD_W-1:0] out_z;
   modport source (output valid, output out_x, output out_y, output out_z, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

>>> hdl/bulge_point_deform_unit.sv
// Bulge point deform unit: top level, configuration registers and main pipeline.
// Depends on bpd_pkg, bpd_if, bpd_udiv, bpd_isqrt and the assertion macro header.
//
// Usage:
//  - Points enter on req_if (valid/ready); each accepted item gives one result
//    on rsp_if, in order.
//  - Bounds, factor, mask, axis and mode are written on the csr_ port while the
//    unit is idle; a write takes effect at the next clock edge.
//  - A result passes 78 register stages from the accepting edge to rsp_if.valid
//    (14 arithmetic stages plus two 32-stage units). Throughput is one item per
//    cycle while the receiver takes results: the ratio divider, the square root
//    and the scale divider are fully pipelined, one quotient or root bit per stage.
//  - Reset clears all stage valid bits and loads the register defaults
//    (bounds 0, factor 1.0, all coordinates enabled, z axis, radial mode).
//  - When the receiver stalls with a result waiting, the whole pipeline holds
//    and req_if.ready drops; nothing is lost or repeated.
`include "bulge_point_deform_unit_defines.svh"
module bulge_point_deform_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bpd_pkg::CSR_DATA_W-1:0] csr_wdata,
   bpd_req_if.sink                        req_if,
   bpd_rsp_if.source                      rsp_if
);
   import bpd_pkg::*;

   localparam int SA_IDX = 3 + UNIT_STAGES;
   localparam logic signed [COORD_W-1:0] ONE    = COORD_W'(1 << FRAC_BITS);
   localparam logic [DIV_Q_W-1:0]        R_CLIP = DIV_Q_W'(1 << 30);

   // configuration registers
   logic signed [COORD_W-1:0] low_ff, high_ff, factor_ff;
   logic [2:0]                mask_ff;
   logic [1:0]                axis_ff;
   logic                      radial_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         high_ff   <= '0;
         factor_ff <= ONE;
         mask_ff   <= DISP_ALL;
         axis_ff   <= AXIS_Z;
         radial_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS_LOW:     low_ff    <= csr_wdata;
            CSR_AXIS_HIGH:    high_ff   <= csr_wdata;
            CSR_BULGE_FACTOR: factor_ff <= csr_wdata;
            CSR_DISP_MASK:    mask_ff   <= csr_wdata[2:0];
            CSR_AXIS_SEL:     axis_ff   <= csr_wdata[1:0];
            CSR_RADIAL_MODE:  radial_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // displaced coordinates: mask bit set and not the bulge axis
   logic [2:0] disp_on;
   always_comb begin
      disp_on = mask_ff;
      case (axis_ff)
         AXIS_X:  disp_on[0] = 1'b0;
         AXIS_Y:  disp_on[1] = 1'b0;
         default: disp_on[2] = 1'b0;
      endcase
   end

   // global advance: hold everything while a result waits
   logic                  adv;
   logic [PIPE_DEPTH-1:0] valid_ff;

   assign adv          = rsp_if.ready || !valid_ff[PIPE_DEPTH-1];
   assign req_if.ready = adv;
   assign rsp_if.valid = valid_ff[PIPE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], req_if.valid};
      end
   end

   // front stages
   logic signed [COORD_W-1:0] s1_c_ff [3];
   logic [WEIGHT_W-1:0]       s1_w_ff, s2_w_ff;
   logic signed [COORD_W-1:0] s2_c_ff [3];
   logic signed [32:0]        s2_len_ff, s2_dist_ff;
   logic [62:0]               s2_sq_ff [3];
   logic signed [COORD_W-1:0] axis_val;
   logic signed [63:0]        sq_in [3];
   logic [SQRT_IN_W-1:0]      s3_sum_ff;
   logic [DIV_NUM_W-1:0]      s3_num_ff;
   logic [DIV_DEN_W-1:0]      s3_den_ff;
   bpd_side_type              s3_side_ff, s3_side_in;
   logic [32:0]               dist_mag, len_mag;

   always_comb begin
      case (axis_ff)
         AXIS_X:  axis_val = s1_c_ff[0];
         AXIS_Y:  axis_val = s1_c_ff[1];
         default: axis_val = s1_c_ff[2];
      endcase
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 64'(s1_c_ff[i]) * 64'(s1_c_ff[i]);
      end
   end

   always_comb begin
      dist_mag        = s2_dist_ff[32] ? 33'(-s2_dist_ff) : s2_dist_ff;
      len_mag         = s2_len_ff[32] ? 33'(-s2_len_ff) : s2_len_ff;
      s3_side_in      = '0;
      s3_side_in.cx   = s2_c_ff[0];
      s3_side_in.cy   = s2_c_ff[1];
      s3_side_in.cz   = s2_c_ff[2];
      s3_side_in.w    = s2_w_ff;
      s3_side_in.neg  = s2_dist_ff[32] ^ s2_len_ff[32];
      s3_side_in.zero = (s2_len_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1: capture, clamp weight to one
         s1_c_ff[0] <= req_if.point_x;
         s1_c_ff[1] <= req_if.point_y;
         s1_c_ff[2] <= req_if.point_z;
         s1_w_ff    <= (req_if.selection_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                              : req_if.selection_weight;
         // stage 2: span, distance, squares
         s2_len_ff  <= 33'(high_ff) - 33'(low_ff);
         s2_dist_ff <= 33'(axis_val) - 33'(low_ff);
         for (int i = 0; i < 3; i++) begin
            s2_c_ff[i]  <= s1_c_ff[i];
            s2_sq_ff[i] <= sq_in[i][62:0];
         end
         s2_w_ff <= s1_w_ff;
         // stage 3: radicand and divider operands
         s3_sum_ff  <= 64'(s2_sq_ff[0]) + 64'(s2_sq_ff[1]) + 64'(s2_sq_ff[2]);
         s3_num_ff  <= {dist_mag, {FRAC_BITS{1'b0}}};
         s3_den_ff  <= len_mag;
         s3_side_ff <= s3_side_in;
      end
   end

   // ratio divider and length, side data delayed alongside
   logic [DIV_Q_W-1:0]    divr_q;
   logic                  divr_ovf;
   logic [SQRT_OUT_W-1:0] len_root;
   bpd_side_type          dl1_ff [UNIT_STAGES];

   bpd_udiv u_div_ratio (
      .clock (clock),
      .en    (adv),
      .num   (s3_num_ff),
      .den   (s3_den_ff),
      .quot  (divr_q),
      .ovf   (divr_ovf)
   );

   bpd_isqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (s3_sum_ff),
      .root  (len_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dl1_ff[0] <= s3_side_ff;
         for (int k = 1; k < UNIT_STAGES; k++) begin
            dl1_ff[k] <= dl1_ff[k-1];
         end
      end
   end

   // middle stages: profile, offset, scale divider operands
   bpd_side_type              sa_side_in, sa_side_ff, sb_side_ff, sc_side_ff;
   bpd_side_type              sd_side_ff, se_side_ff, sf_side_ff;
   bpd_side_type              se_side_in, sf_side_in;
   logic [DIV_Q_W-1:0]        r_mag;
   logic signed [COORD_W-1:0] sa_r_ff;
   logic signed [64:0]        sb_p_ff;
   logic signed [COORD_W-1:0] sc_delta_ff;
   logic signed [63:0]        sd_fo_ff;
   logic signed [33:0]        n_sum;
   logic [32:0]               n_mag;
   logic [DIV_NUM_W-1:0]      sf_num_ff;
   logic [DIV_DEN_W-1:0]      sf_den_ff;

   always_comb begin
      sa_side_in      = dl1_ff[UNIT_STAGES-1];
      sa_side_in.d    = len_root;
      r_mag           = (divr_ovf || divr_q > R_CLIP) ? R_CLIP : divr_q;
      // offset joins the side data
      se_side_in      = sd_side_ff;
      se_side_in.o    = sat32(SAT_W'(sd_fo_ff >>> FRAC_BITS));
      n_sum           = $signed({2'b00, se_side_ff.d}) + 34'(se_side_ff.o);
      n_mag           = n_sum[33] ? 33'(-n_sum) : n_sum[32:0];
      // sign and zero length for the scale divider
      sf_side_in      = se_side_ff;
      sf_side_in.neg  = n_sum[33];
      sf_side_in.zero = (se_side_ff.d == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // signed ratio, clipped
         sa_r_ff    <= sa_side_in.neg ? -r_mag : r_mag;
         sa_side_ff <= sa_side_in;
         // r * (one - r)
         sb_p_ff    <= 65'(sa_r_ff) * (65'(ONE) - 65'(sa_r_ff));
         sb_side_ff <= sa_side_ff;
         // delta, zero span gives no bulge
         sc_delta_ff <= sb_side_ff.zero ? '0
                                        : sat32(SAT_W'(sb_p_ff >>> (FRAC_BITS - 1)));
         sc_side_ff  <= sb_side_ff;
         // factor * delta
         sd_fo_ff   <= 64'(factor_ff) * 64'(sc_delta_ff);
         sd_side_ff <= sc_side_ff;
         // offset
         se_side_ff <= se_side_in;
         // (d + o) / d operands
         sf_num_ff  <= {n_mag, {FRAC_BITS{1'b0}}};
         sf_den_ff  <= {1'b0, se_side_ff.d};
         sf_side_ff <= sf_side_in;
      end
   end

   // scale divider, side data delayed alongside
   logic [DIV_Q_W-1:0] divs_q;
   logic               divs_ovf;
   bpd_side_type       dl2_ff [UNIT_STAGES];

   bpd_udiv u_div_scale (
      .clock (clock),
      .en    (adv),
      .num   (sf_num_ff),
      .den   (sf_den_ff),
      .quot  (divs_q),
      .ovf   (divs_ovf)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dl2_ff[0] <= sf_side_ff;
         for (int k = 1; k < UNIT_STAGES; k++) begin
            dl2_ff[k] <= dl2_ff[k-1];
         end
      end
   end

   // back stages: scale, deform, blend, saturate
   bpd_side_type              sg_side;
   logic signed [COORD_W-1:0] scale_in;
   logic signed [COORD_W-1:0] sg_scale_ff;
   logic signed [COORD_W-1:0] sg_c_ff [3];
   logic signed [COORD_W-1:0] sg_o_ff, sh_o_ff;
   logic [WEIGHT_W-1:0]       sg_w_ff, sh_w_ff, si_w_ff;
   logic signed [63:0]        sh_p_ff [3];
   logic signed [COORD_W-1:0] sh_c_ff [3];
   logic signed [COORD_W-1:0] si_n_ff [3];
   logic signed [COORD_W-1:0] si_c_ff [3];
   logic signed [33:0]        diff_in [3];
   logic signed [51:0]        sj_b_ff [3];
   logic signed [COORD_W-1:0] sj_c_ff [3];
   logic signed [COORD_W-1:0] sk_out_ff [3];

   always_comb begin
      sg_side = dl2_ff[UNIT_STAGES-1];
      if (sg_side.zero) begin
         scale_in = ONE;
      end else if (divs_ovf) begin
         scale_in = sg_side.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (sg_side.neg) begin
         scale_in = (divs_q[DIV_Q_W-1] && (|divs_q[DIV_Q_W-2:0])) ? 32'sh80000000
                                                                  : -divs_q;
      end else begin
         scale_in = divs_q[DIV_Q_W-1] ? 32'sh7FFFFFFF : divs_q;
      end
      for (int i = 0; i < 3; i++) begin
         diff_in[i] = 34'(si_n_ff[i]) - 34'(si_c_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sg_scale_ff <= scale_in;
         sg_c_ff[0]  <= sg_side.cx;
         sg_c_ff[1]  <= sg_side.cy;
         sg_c_ff[2]  <= sg_side.cz;
         sg_o_ff     <= sg_side.o;
         sg_w_ff     <= sg_side.w;
         sh_o_ff     <= sg_o_ff;
         sh_w_ff     <= sg_w_ff;
         si_w_ff     <= sh_w_ff;
         for (int i = 0; i < 3; i++) begin
            // coordinate times scale
            sh_p_ff[i] <= 64'(sg_c_ff[i]) * 64'(sg_scale_ff);
            sh_c_ff[i] <= sg_c_ff[i];
            // deformed coordinate
            if (!disp_on[i]) begin
               si_n_ff[i] <= sh_c_ff[i];
            end else if (radial_ff) begin
               si_n_ff[i] <= sat32(SAT_W'(sh_p_ff[i] >>> FRAC_BITS));
            end else begin
               si_n_ff[i] <= sat32(SAT_W'(sh_c_ff[i]) + SAT_W'(sh_o_ff));
            end
            si_c_ff[i] <= sh_c_ff[i];
            // weighted difference
            sj_b_ff[i] <= 52'(diff_in[i]) * $signed({35'd0, si_w_ff});
            sj_c_ff[i] <= si_c_ff[i];
            // blend and saturate into the output register
            sk_out_ff[i] <= sat32(SAT_W'(sj_c_ff[i]) + SAT_W'(sj_b_ff[i] >>> WEIGHT_BITS));
         end
      end
   end

   assign rsp_if.out_x = sk_out_ff[0];
   assign rsp_if.out_y = sk_out_ff[1];
   assign rsp_if.out_z = sk_out_ff[2];

   // checks
   `BPD_ASSERT_IMPLIES(a_ready_when_out_empty, !rsp_if.valid, req_if.ready, "input stalled with empty output")
   `BPD_ASSERT_IMPLIES(a_weight_clamped, valid_ff[0], s1_w_ff <= WEIGHT_ONE, "weight above one after clamp")
   `BPD_ASSERT_IMPLIES(a_ratio_bounded, valid_ff[SA_IDX], (sa_r_ff <= 32'sd1073741824) && (sa_r_ff >= -32'sd1073741824), "ratio outside clip range")

endmodule

>>> hdl/bpd_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpd_pkg; flags quotients that do not fit in DIV_Q_W bits.
module bpd_udiv (
   input  logic                          clock,
   input  logic                          en,
   input  logic [bpd_pkg::DIV_NUM_W-1:0] num,
   input  logic [bpd_pkg::DIV_DEN_W-1:0] den,
   output logic [bpd_pkg::DIV_Q_W-1:0]   quot,
   output logic                          ovf
);
   import bpd_pkg::*;

   localparam int REM_W = DIV_DEN_W + 1;

   logic [REM_W-1:0]     rem_ff [UNIT_STAGES];
   logic [REM_W-1:0]     rem_in [UNIT_STAGES];
   logic [DIV_Q_W-1:0]   lo_ff  [UNIT_STAGES];
   logic [DIV_Q_W-1:0]   lo_in  [UNIT_STAGES];
   logic [DIV_Q_W-1:0]   q_ff   [UNIT_STAGES];
   logic [DIV_Q_W-1:0]   q_in   [UNIT_STAGES];
   logic [DIV_DEN_W-1:0] den_ff [UNIT_STAGES];
   logic [DIV_DEN_W-1:0] den_in [UNIT_STAGES];
   logic                 ovf_ff [UNIT_STAGES];
   logic                 ovf_in [UNIT_STAGES];

   // one shift-compare-subtract per stage
   always_comb begin
      logic [REM_W-1:0]     p_rem;
      logic [REM_W-1:0]     trial;
      logic [DIV_Q_W-1:0]   p_lo;
      logic [DIV_Q_W-1:0]   p_q;
      logic [DIV_DEN_W-1:0] p_den;
      logic                 p_ovf;
      for (int k = 0; k < UNIT_STAGES; k++) begin
         if (k == 0) begin
            p_rem = REM_W'(num[DIV_NUM_W-1:DIV_Q_W]);
            p_lo  = num[DIV_Q_W-1:0];
            p_q   = '0;
            p_den = den;
            p_ovf = (REM_W'(num[DIV_NUM_W-1:DIV_Q_W]) >= REM_W'(den));
         end else begin
            p_rem = rem_ff[k-1];
            p_lo  = lo_ff[k-1];
            p_q   = q_ff[k-1];
            p_den = den_ff[k-1];
            p_ovf = ovf_ff[k-1];
         end
         trial = {p_rem[REM_W-2:0], p_lo[DIV_Q_W-1]};
         if (trial >= REM_W'(p_den)) begin
            rem_in[k] = trial - REM_W'(p_den);
            q_in[k]   = {p_q[DIV_Q_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial;
            q_in[k]   = {p_q[DIV_Q_W-2:0], 1'b0};
         end
         lo_in[k]  = {p_lo[DIV_Q_W-2:0], 1'b0};
         den_in[k] = p_den;
         ovf_in[k] = p_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < UNIT_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            q_ff[k]   <= q_in[k];
            den_ff[k] <= den_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quot = q_ff[UNIT_STAGES-1];
   assign ovf  = ovf_ff[UNIT_STAGES-1];

endmodule

>>> hdl/bpd_isqrt.sv
// Pipelined integer square root, two radicand bits and one root bit per stage.
// Depends on bpd_pkg; result is floor(sqrt(rad)).
module bpd_isqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [bpd_pkg::SQRT_IN_W-1:0]  rad,
   output logic [bpd_pkg::SQRT_OUT_W-1:0] root
);
   import bpd_pkg::*;

   localparam int REM_W = SQRT_OUT_W + 3;

   logic [REM_W-1:0]      rem_ff  [UNIT_STAGES];
   logic [REM_W-1:0]      rem_in  [UNIT_STAGES];
   logic [SQRT_OUT_W-1:0] root_ff [UNIT_STAGES];
   logic [SQRT_OUT_W-1:0] root_in [UNIT_STAGES];
   logic [SQRT_IN_W-1:0]  rad_ff  [UNIT_STAGES];
   logic [SQRT_IN_W-1:0]  rad_in  [UNIT_STAGES];

   // bring down two bits, try root*4+1
   always_comb begin
      logic [REM_W-1:0]      p_rem;
      logic [REM_W-1:0]      cur;
      logic [REM_W-1:0]      trial;
      logic [SQRT_OUT_W-1:0] p_root;
      logic [SQRT_IN_W-1:0]  p_rad;
      for (int k = 0; k < UNIT_STAGES; k++) begin
         if (k == 0) begin
            p_rem  = '0;
            p_root = '0;
            p_rad  = rad;
         end else begin
            p_rem  = rem_ff[k-1];
            p_root = root_ff[k-1];
            p_rad  = rad_ff[k-1];
         end
         cur   = {p_rem[REM_W-3:0], p_rad[SQRT_IN_W-1:SQRT_IN_W-2]};
         trial = REM_W'({p_root, 2'b01});
         if (cur >= trial) begin
            rem_in[k]  = cur - trial;
            root_in[k] = {p_root[SQRT_OUT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = cur;
            root_in[k] = {p_root[SQRT_OUT_W-2:0], 1'b0};
         end
         rad_in[k] = {p_rad[SQRT_IN_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < UNIT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root = root_ff[UNIT_STAGES-1];

endmodule

>>> bench/tb.sv
// Self-checking bench for bulge_point_deform_unit: random and directed points
// under several register settings, each result checked against a local predictor.
// Depends on bpd_pkg and the bpd_req_if / bpd_rsp_if interfaces.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bpd_pkg::*;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [WEIGHT_W-1:0]       w;
   } point_item_type;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } deformed_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bpd_req_if req_if ();
   bpd_rsp_if rsp_if ();

   bulge_point_deform_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .rsp_if    (rsp_if)
   );

   always #1 clock = ~clock;

   // shadow copy of the registers
   logic signed [31:0] sh_low = 0;
   logic signed [31:0] sh_high = 0;
   logic signed [31:0] sh_factor = 32'sd65536;
   logic [2:0]         sh_mask = DISP_ALL;
   logic [1:0]         sh_axis = AXIS_Z;
   logic               sh_radial = 1'b1;

   point_item_type     pending_points[$];
   deformed_point_type expected_points[$];
   int  fails = 0;
   bit  quiet = 0;
   bit  req_taken = 0;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(root);
   endfunction

   // bulge profile, displacement and blend for one point
   function automatic deformed_point_type deform_point(point_item_type p);
      deformed_point_type res;
      longint one, lo, hi, fac, span, r, delta, offs, w, d, scale, t;
      longint c[3];
      longint nv[3];
      longint unsigned sq;
      int ax;
      bit on;
      one = 64'sd65536;
      lo = sh_low;
      hi = sh_high;
      fac = sh_factor;
      ax = (sh_axis == 2'd3) ? 2 : int'(sh_axis);
      c[0] = p.x;
      c[1] = p.y;
      c[2] = p.z;
      w = p.w;
      if (w > 65536) w = 65536;
      delta = 0;
      span = hi - lo;
      if (span != 0) begin
         r = ((c[ax] - lo) * one) / span;
         if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
         if (r < -(64'sd1 <<< 30)) r = -(64'sd1 <<< 30);
         delta = clip32((2 * r * (one - r)) >>> 16);
      end
      offs = clip32((fac * delta) >>> 16);
      if (sh_radial) begin
         sq = longint'(c[0] * c[0]) + longint'(c[1] * c[1]) + longint'(c[2] * c[2]);
         d = int_sqrt(sq);
         scale = one;
         if (d != 0) scale = clip32(((d + offs) * one) / d);
      end
      for (int i = 0; i < 3; i++) begin
         on = sh_mask[i] && (i != ax);
         if (!on) nv[i] = c[i];
         else if (sh_radial) nv[i] = clip32((c[i] * scale) >>> 16);
         else nv[i] = clip32(c[i] + offs);
      end
      t = clip32(c[0] + (((nv[0] - c[0]) * w) >>> 16));
      res.x = t[31:0];
      t = clip32(c[1] + (((nv[1] - c[1]) * w) >>> 16));
      res.y = t[31:0];
      t = clip32(c[2] + (((nv[2] - c[2]) * w) >>> 16));
      res.z = t[31:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fails++;
   endtask

   // register write, mirrored into the shadow copy
   task automatic csr_write(csr_index_type idx, logic [31:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AXIS_LOW:     sh_low = v;
         CSR_AXIS_HIGH:    sh_high = v;
         CSR_BULGE_FACTOR: sh_factor = v;
         CSR_DISP_MASK:    sh_mask = v[2:0];
         CSR_AXIS_SEL:     sh_axis = v[1:0];
         CSR_RADIAL_MODE:  sh_radial = v[0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [31:0] lo, logic [31:0] hi, logic [31:0] fac,
                                logic [2:0] mask, logic [1:0] ax, logic rad);
      csr_write(CSR_AXIS_LOW, lo);
      csr_write(CSR_AXIS_HIGH, hi);
      csr_write(CSR_BULGE_FACTOR, fac);
      csr_write(CSR_DISP_MASK, {29'd0, mask});
      csr_write(CSR_AXIS_SEL, {30'd0, ax});
      csr_write(CSR_RADIAL_MODE, {31'd0, rad});
   endtask

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [16:0] w);
      point_item_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      p.w = w;
      pending_points = {pending_points, p};
   endtask

   task automatic drain;
      wait (pending_points.size() == 0 && expected_points.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // coordinate mix: full range, small values, or around the bounds
   function automatic logic [31:0] pick_coord();
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         default: begin
            lo = sh_low;
            hi = sh_high;
            return 32'(lo + $signed($urandom_range(2047) - 256) * ((hi - lo) >>> 10));
         end
      endcase
   endfunction

   function automatic logic [16:0] pick_weight();
      case ($urandom_range(3))
         0: return 17'd65536;
         1: return 17'($urandom);
         default: return 17'($urandom_range(65536));
      endcase
   endfunction

   task automatic random_points(int count);
      for (int i = 0; i < count; i++) begin
         add_point(pick_coord(), pick_coord(), pick_coord(), pick_weight());
      end
   endtask

   // point driver: holds an item until taken, then may idle
   always @(posedge clock) begin
      req_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
         expected_points = {expected_points, deform_point(pending_points[0])};
         void'(pending_points.pop_front());
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_points.size() > 0 && (quiet || $urandom_range(99) >= 37)) begin
            req_if.valid <= 1'b1;
            req_if.point_x <= pending_points[0].x;
            req_if.point_y <= pending_points[0].y;
            req_if.point_z <= pending_points[0].z;
            req_if.selection_weight <= pending_points[0].w;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result monitor
   always @(negedge clock) begin
      rsp_if.ready <= !reset && (quiet || $urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if (rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            $display("unexpected result item at %0t", $realtime);
            fails++;
         end else begin
            if (rsp_if.out_x !== expected_points[0].x)
               report_mismatch("out_x", rsp_if.out_x, expected_points[0].x);
            if (rsp_if.out_y !== expected_points[0].y)
               report_mismatch("out_y", rsp_if.out_y, expected_points[0].y);
            if (rsp_if.out_z !== expected_points[0].z)
               report_mismatch("out_z", rsp_if.out_z, expected_points[0].z);
            void'(expected_points.pop_front());
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.point_z = '0;
      req_if.selection_weight = '0;
      rsp_if.ready = 1'b0;
   end

   // stimulus sequence
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: equal bounds, so no bulge; origin and extremes
      add_point(0, 0, 0, 17'd65536);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 17'd65536);
      add_point(32'h80000000, 32'h80000000, 32'h80000000, 17'h1FFFF);
      add_point(32'hFFFFFFFF, 32'h00010000, 32'h00000001, 17'd0);
      drain();

      // bounds 0..4 on z, radial, then points inside, on and outside the bounds
      load_settings(0, 32'h0004_0000, 32'h0002_0000, DISP_ALL, AXIS_Z, 1'b1);
      add_point(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 17'd65536);
      add_point(32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000, 17'd65536);
      add_point(32'h0003_0000, 32'h0000_8000, 32'h0000_0000, 17'd32768);
      add_point(0, 0, 0, 17'd65536);
      add_point(32'h0001_0000, 32'h0001_0000, 32'h0010_0000, 17'd65536);
      add_point(32'h0001_0000, 32'h0001_0000, 32'h8000_0000, 17'h1FFFF);
      drain();

      // linear mode, y axis with its mask bit set, reversed bounds
      load_settings(32'h0004_0000, 32'hFFFC_0000, 32'h7FFFFFFF, DISP_ALL, AXIS_Y, 1'b0);
      add_point(32'h7FFF0000, 32'h0000_0000, 32'h8000_0000, 17'd65536);
      add_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 17'd100);
      drain();

      // fourth axis code, partial mask, minimum factor
      load_settings(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 3'b011, 2'd3, 1'b1);
      add_point(32'h4000_0000, 32'hC000_0000, 32'h0000_0000, 17'd65536);
      add_point(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 17'd65536);
      drain();
      load_settings(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 3'b000, AXIS_X, 1'b0);
      add_point(32'h0000_0000, 32'h1234_5678, 32'h8765_4321, 17'd65536);
      drain();

      // random phases, each under its own settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_settings(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, DISP_ALL,
                             AXIS_X, 1'b1);
            1: load_settings(0, 0, 32'h0001_0000, DISP_ALL, AXIS_Z, 1'b0);
            default: load_settings($urandom, $urandom, $urandom, 3'($urandom),
                                   2'($urandom), 1'($urandom));
         endcase
         if (ph > 4) begin
            load_settings(32'($signed($urandom_range(1 << 22)) - (1 << 21)),
                          32'($signed($urandom_range(1 << 22)) + (1 << 16)),
                          32'($signed($urandom_range(1 << 19)) - (1 << 18)),
                          3'($urandom), 2'($urandom_range(2)), 1'($urandom));
         end
         quiet = (ph == 3);
         random_points(48);
         drain();
      end
      quiet = 0;

      repeat (200) @(posedge clock);
      if (fails == 0 && expected_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
